[design/ovle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovle_pkg
// Shared types, widths and codes for the ordered value list engine.
// ----------------------------------------------------------------------------
package ovle_pkg;

  localparam int CAPACITY = 16;

  // field widths
  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;

  // entry count holds 0..CAPACITY, cell index 0..CAPACITY-1
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // compare width: wide enough for position, count and count + 1
  localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // ops
  localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND     = 3'd3;
  localparam logic [OP_W-1:0] OP_TRAVERSE = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

  // cell commands
  typedef logic [1:0] cell_cmd_t;
  localparam cell_cmd_t CELL_HOLD       = 2'd0;
  localparam cell_cmd_t CELL_LOAD       = 2'd1;
  localparam cell_cmd_t CELL_TAKE_LEFT  = 2'd2;
  localparam cell_cmd_t CELL_TAKE_RIGHT = 2'd3;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      active;  // cell lies inside the list
  } cell_ctrl_t;

endpackage

[design/ovle_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovle_in_if / ovle_out_if
// Valid/ready channels for list commands and list results.
// ----------------------------------------------------------------------------
interface ovle_in_if;
  import ovle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ovle_out_if;
  import ovle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [POS_W-1:0]         found_position;
  logic signed [VAL_W-1:0]  entry_value;
  logic                     last;

  modport source (output valid, output status, output found_position,
                  output entry_value, output last, input ready);
  modport sink   (input valid, input status, input found_position,
                  input entry_value, input last, output ready);
endinterface

[design/ovle_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovle_cell
// One list slot: holds a value, shifts to/from neighbors, compares to a key.
// ----------------------------------------------------------------------------
module ovle_cell import ovle_pkg::*; (
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] new_data,
  input  logic signed [VAL_W-1:0] left_data,
  input  logic signed [VAL_W-1:0] right_data,
  input  logic signed [VAL_W-1:0] key,
  output logic signed [VAL_W-1:0] value,
  output logic                    hit
);

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;

  always_comb begin
    case (ctrl.cmd)
      CELL_LOAD:       value_nxt = new_data;
      CELL_TAKE_LEFT:  value_nxt = left_data;
      CELL_TAKE_RIGHT: value_nxt = right_data;
      default:         value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign hit   = ctrl.active && (value_r == key);

endmodule

[design/ordered_value_list_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list_engine_core
// Positional list of signed values: append, insert, delete, find, traverse,
// clear, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage: append, insert, delete, find and clear each give exactly one result
// transaction; the parallel compare in every cell settles find and the
// neighbor shifts settle insert and delete. A traverse of a list of N
// entries streams N results, one per cycle unless the output is stalled,
// by rotating the cell row left one slot per result, so the list is intact
// when the last result goes out; an empty list gives one list-empty result.
// One command is in flight at a time: a new command is taken when no
// traverse is streaming and the output register is free or being drained.
// Entry storage has no reset; only slots below the entry count are read.
// ----------------------------------------------------------------------------
module ordered_value_list_engine_core import ovle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ovle_in_if.sink           in_ch,
  ovle_out_if.source        out_ch
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_TRAV = 1'b1;

  // control state
  logic             state_r,     state_nxt;
  logic [CNT_W-1:0] count_r,     count_nxt;
  logic [IDX_W-1:0] trav_idx_r,  trav_idx_nxt;
  logic             out_valid_r, out_valid_nxt;

  // output payload
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [POS_W-1:0]        out_pos_r,    out_pos_nxt;
  logic signed [VAL_W-1:0] out_value_r,  out_value_nxt;
  logic                    out_last_r,   out_last_nxt;

  // cell row
  cell_ctrl_t              cell_ctrl [CAPACITY];
  logic signed [VAL_W-1:0] cell_val  [CAPACITY];
  logic [CAPACITY-1:0]     cell_hit;
  logic signed [VAL_W-1:0] new_data;

  logic out_free, in_fire, emit;
  logic [CW-1:0] pos_w, cnt_w, ppos_w;
  logic full, pos_ins_ok, pos_del_ok;
  logic do_append, do_insert, do_delete;
  logic trav_last;
  logic [CW-1:0] trav_pos_w;

  // find: first matching cell
  logic             find_hit;
  logic [IDX_W-1:0] find_idx;
  logic [CW-1:0]    find_pos_w;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign emit = (state_r == S_TRAV) && out_free;

  assign pos_w  = CW'(in_ch.position);
  assign cnt_w  = CW'(count_r);
  assign ppos_w = pos_w - CW'(1);
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign pos_ins_ok = (pos_w != '0) && (pos_w <= cnt_w + CW'(1));
  assign pos_del_ok = (pos_w != '0) && (pos_w <= cnt_w);

  assign do_append = in_fire && (in_ch.op == OP_APPEND) && !full;
  assign do_insert = in_fire && (in_ch.op == OP_INSERT) && pos_ins_ok && !full;
  assign do_delete = in_fire && (in_ch.op == OP_DELETE) && (count_r != '0) && pos_del_ok;

  assign trav_last  = (CW'(trav_idx_r) + CW'(1)) == cnt_w;
  assign trav_pos_w = CW'(trav_idx_r) + CW'(1);

  // during traverse the head value wraps into the tail slot
  assign new_data = emit ? cell_val[0] : in_ch.value;

  always_comb begin
    find_hit = 1'b0;
    find_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_hit[i]) begin
        find_hit = 1'b1;
        find_idx = IDX_W'(i);
      end
    end
  end
  assign find_pos_w = CW'(find_idx) + CW'(1);

  // per-cell command decode and the chain itself
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(gi);
    logic signed [VAL_W-1:0] left_data;
    logic signed [VAL_W-1:0] right_data;

    if (gi == 0) begin : g_head
      assign left_data = cell_val[gi];
    end else begin : g_body
      assign left_data = cell_val[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_tail
      assign right_data = cell_val[gi];
    end else begin : g_inner
      assign right_data = cell_val[gi+1];
    end

    always_comb begin
      cell_ctrl[gi].active = (IDX < cnt_w);
      cell_ctrl[gi].cmd    = CELL_HOLD;
      if (do_append && (IDX == cnt_w)) begin
        cell_ctrl[gi].cmd = CELL_LOAD;
      end
      if (do_insert) begin
        if (IDX == ppos_w) begin
          cell_ctrl[gi].cmd = CELL_LOAD;
        end else if ((IDX > ppos_w) && (IDX <= cnt_w)) begin
          cell_ctrl[gi].cmd = CELL_TAKE_LEFT;
        end
      end
      if (do_delete && (IDX >= ppos_w) && (IDX + CW'(1) < cnt_w)) begin
        cell_ctrl[gi].cmd = CELL_TAKE_RIGHT;
      end
      if (emit) begin
        if (IDX + CW'(1) < cnt_w) begin
          cell_ctrl[gi].cmd = CELL_TAKE_RIGHT;
        end else if (IDX + CW'(1) == cnt_w) begin
          cell_ctrl[gi].cmd = CELL_LOAD;
        end
      end
    end

    ovle_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[gi]),
      .new_data   (new_data),
      .left_data  (left_data),
      .right_data (right_data),
      .key        (in_ch.value),
      .value      (cell_val[gi]),
      .hit        (cell_hit[gi])
    );
  end

  // command sequencing and result formation
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    trav_idx_nxt   = trav_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;

    if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      // default single-result shape
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_pos_nxt    = '0;
      out_value_nxt  = '0;
      out_last_nxt   = 1'b1;
      case (in_ch.op)
        OP_APPEND: begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_INSERT: begin
          if (!pos_ins_ok) begin
            out_status_nxt = ST_BAD_POS;
          end else if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (count_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else if (!pos_del_ok) begin
            out_status_nxt = ST_BAD_POS;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_FIND: begin
          if (find_hit) begin
            out_pos_nxt   = find_pos_w[POS_W-1:0];
            out_value_nxt = in_ch.value;
          end else begin
            out_status_nxt = ST_NOT_FOUND;
          end
        end
        OP_TRAVERSE: begin
          if (count_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            // results stream from the traverse state
            out_valid_nxt = 1'b0;
            state_nxt     = S_TRAV;
            trav_idx_nxt  = '0;
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_pos_nxt    = trav_pos_w[POS_W-1:0];
      out_value_nxt  = cell_val[0];
      out_last_nxt   = trav_last;
      trav_idx_nxt   = trav_idx_r + IDX_W'(1);
      if (trav_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      trav_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      trav_idx_r  <= trav_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found_position = out_pos_r;
  assign out_ch.entry_value    = out_value_r;
  assign out_ch.last           = out_last_r;

  // list never grows past the cell row
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // a traverse only runs over a non-empty list
  a_trav_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRAV) |-> (count_r != '0))
    else $error("traverse running on empty list");

  // rotation must not change the list length
  a_trav_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRAV) |=> $stable(count_r))
    else $error("entry count changed during traverse");

  // the final traverse transaction returns control to idle, marked last
  a_trav_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && trav_last) |=> ((state_r == S_IDLE) && out_last_r && out_valid_r))
    else $error("traverse did not close on its last entry");

endmodule
